@@ src/rntoa_pkg.sv @@
package rntoa_pkg;

   // width of the value field on the port, fixed
   localparam int VALUE_FIELD_W = 64;

   // default number of low value bits that take part
   localparam int VALUE_WIDTH_DEF = 64;

   // entries of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // operation field codes
   localparam logic [1:0] OP_BIN = 2'd0;
   localparam logic [1:0] OP_DEC = 2'd1;

   // radix codes after classification
   localparam logic [1:0] RADIX_BIN = 2'd0;
   localparam logic [1:0] RADIX_DEC = 2'd1;
   localparam logic [1:0] RADIX_HEX = 2'd2;

   localparam logic [6:0] ASCII_DIGIT_BASE  = 7'h30;
   localparam logic [6:0] ASCII_LETTER_BASE = 7'h40;
   localparam logic [6:0] LETTER_OFFSET     = 7'd9;
   localparam logic [3:0] DIGIT_LIMIT       = 4'd10;

   function automatic logic [6:0] ascii_of_digit(input logic [3:0] digit);
      logic [6:0] ch;
      if (digit < DIGIT_LIMIT) begin
         ch = ASCII_DIGIT_BASE + {3'b000, digit};
      end else begin
         ch = ASCII_LETTER_BASE + {3'b000, digit} - LETTER_OFFSET;
      end
      return ch;
   endfunction

endpackage

@@ src/rntoa_front.sv @@
module rntoa_front
   import rntoa_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [VALUE_FIELD_W-1:0] req_value,
   input  logic [1:0]               req_operation,
   output logic                     push_valid,
   input  logic                     push_ready,
   output logic [VALUE_WIDTH+1:0]   push_data
);

   logic                   valid_ff, valid_in;
   logic [1:0]             radix_ff, radix_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   accept;
   logic                   push;

   assign req_stall  = valid_ff && !push_ready;
   assign accept     = req_valid && !req_stall;
   assign push       = valid_ff && push_ready;
   assign push_valid = valid_ff;
   assign push_data  = {radix_ff, value_ff};

   // operation 3 decodes as hex: only the decimal and binary codes are singled out
   always_comb begin
      valid_in = valid_ff;
      radix_in = radix_ff;
      value_in = value_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
         value_in = req_value[VALUE_WIDTH-1:0];
         if (req_operation == OP_DEC) begin
            radix_in = RADIX_DEC;
         end else if (req_operation == OP_BIN) begin
            radix_in = RADIX_BIN;
         end else begin
            radix_in = RADIX_HEX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      radix_ff <= radix_in;
      value_ff <= value_in;
   end

endmodule

@@ src/rntoa_fifo.sv @@
module rntoa_fifo
   import rntoa_pkg::*;
#(
   parameter int DATA_W = VALUE_WIDTH_DEF + 2,
   parameter int DEPTH  = QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0]  entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               push, pop;

   assign push_ready = count_ff != COUNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/rntoa_back.sv @@
module rntoa_back
   import rntoa_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  logic [VALUE_WIDTH+1:0] pop_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [6:0]             rsp_ascii_char,
   output logic                   rsp_last_char
);

   localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
   localparam int HEX_W      = 4 * HEX_DIGITS;
   // floor(w * log10(2)) + 1 decimal digits
   localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   // the bcd field is at least as wide as the hex and binary images
   localparam int SH_W       = 4 * DEC_DIGITS;
   localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DABBLE = 2'd1;
   localparam logic [1:0] ST_SKIP   = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [1:0]             radix_ff, radix_in;
   logic [SH_W-1:0]        sh_ff, sh_in;
   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [CNT_W-1:0]       step_ff, step_in;

   logic                   is_bin;
   logic [3:0]             top_digit;
   logic [SH_W-1:0]        sh_shifted;
   logic [SH_W-1:0]        sh_corr;
   logic [VALUE_WIDTH-1:0] pop_value;
   logic [1:0]             pop_radix;

   assign pop_value = pop_data[VALUE_WIDTH-1:0];
   assign pop_radix = pop_data[VALUE_WIDTH+1:VALUE_WIDTH];

   assign is_bin     = radix_ff == RADIX_BIN;
   assign top_digit  = is_bin ? {3'b000, sh_ff[SH_W-1]} : sh_ff[SH_W-1 -: 4];
   assign sh_shifted = is_bin ? {sh_ff[SH_W-2:0], 1'b0} : {sh_ff[SH_W-5:0], 4'b0000};

   // add 3 to every bcd digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         sh_corr[4*i +: 4] = (sh_ff[4*i +: 4] >= 4'd5) ? sh_ff[4*i +: 4] + 4'd3
                                                       : sh_ff[4*i +: 4];
      end
   end

   assign pop_ready      = state_ff == ST_IDLE;
   assign rsp_valid      = state_ff == ST_EMIT;
   assign rsp_ascii_char = ascii_of_digit(top_digit);
   assign rsp_last_char  = cnt_ff == CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      radix_in = radix_ff;
      sh_in    = sh_ff;
      bin_in   = bin_ff;
      cnt_in   = cnt_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               radix_in = pop_radix;
               bin_in   = pop_value;
               sh_in    = '0;
               case (pop_radix)
                  RADIX_BIN: begin
                     sh_in[SH_W-1 -: VALUE_WIDTH] = pop_value;
                     cnt_in   = CNT_W'(VALUE_WIDTH);
                     state_in = ST_SKIP;
                  end
                  RADIX_DEC: begin
                     step_in  = CNT_W'(VALUE_WIDTH);
                     cnt_in   = CNT_W'(DEC_DIGITS);
                     state_in = ST_DABBLE;
                  end
                  default: begin
                     sh_in[SH_W-1 -: HEX_W] = HEX_W'(pop_value);
                     cnt_in   = CNT_W'(HEX_DIGITS);
                     state_in = ST_SKIP;
                  end
               endcase
            end
         end
         ST_DABBLE: begin
            sh_in   = {sh_corr[SH_W-2:0], bin_ff[VALUE_WIDTH-1]};
            bin_in  = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
            step_in = step_ff - 1'b1;
            if (step_ff == CNT_W'(1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, keeping at least one digit
            if (cnt_ff != CNT_W'(1) && top_digit == 4'd0) begin
               sh_in  = sh_shifted;
               cnt_in = cnt_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  sh_in  = sh_shifted;
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      radix_ff <= radix_in;
      sh_ff    <= sh_in;
      bin_ff   <= bin_in;
      cnt_ff   <= cnt_in;
      step_ff  <= step_in;
   end

`ifndef ASSERT_OFF
   a_dec_digit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && radix_ff == RADIX_DEC) |-> top_digit <= 4'd9)
      else $error("decimal digit out of range");

   a_last_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_char && !rsp_stall) |=> state_ff == ST_IDLE)
      else $error("back did not return to idle after last digit");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKIP || state_ff == ST_EMIT) |-> cnt_ff != '0)
      else $error("digit count ran out");

   a_dabble_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DABBLE && step_ff == CNT_W'(1)) |=> state_ff == ST_SKIP)
      else $error("bcd conversion did not finish");
`endif

endmodule

@@ src/radix_number_to_ascii.sv @@
// path: front register, queue, then back states idle, dabble (decimal only), skip and emit;
//   leading zero digits are dropped in skip, and a response stall holds the back in emit
// items: back takes no new item until it has sent the last digit of the one it holds;
//   the queue keeps the input open while it has room
// reset: synchronous, active high; clears valid flags, queue pointers and back state
module radix_number_to_ascii
   import rntoa_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // input items: value and radix select
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [VALUE_FIELD_W-1:0] req_value,
   input  logic [1:0]               req_operation,
   // result items: one ascii digit each, most significant first
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [6:0]               rsp_ascii_char,
   output logic                     rsp_last_char
);

   // queue entry holds radix code above the masked value
   localparam int ENTRY_W = VALUE_WIDTH + 2;

   logic               push_valid;
   logic               push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid;
   logic               pop_ready;
   logic [ENTRY_W-1:0] pop_data;

   // front: takes the item, masks the value, classifies the radix
   rntoa_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .req_operation (req_operation),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_data     (push_data)
   );

   // short queue so front and back stall independently
   rntoa_fifo #(
      .DATA_W (ENTRY_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: bcd conversion for decimal, leading zero skip, digit output
   rntoa_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last_char  (rsp_last_char)
   );

endmodule
